// File: design/spa_pkg.sv
// spa_pkg: shared types and elaboration-time coefficient functions for the
// odd-polynomial sine pipeline. No dependencies.
`timescale 1ns / 1ps

package spa_pkg;

  localparam int ANGLE_W  = 32;
  localparam int RESULT_W = 32;
  localparam int MODE_W   = 2;
  localparam int HORNER_STEPS = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_TAYLOR7 = 2'd0,
    MODE_TAYLOR9 = 2'd1,
    MODE_CHEB    = 2'd2
  } mode_e;

  // num/den rounded to frac fraction bits, ties away from zero, by long division
  function automatic logic signed [63:0] fix_coef(input logic [63:0] num,
                                                  input logic [63:0] den,
                                                  input logic        neg,
                                                  input int          frac);
    logic [63:0] v;
    logic [63:0] r;
    int          i;
    v = '0;
    r = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      v = {v[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        v[0] = 1'b1;
      end
    end
    for (i = 0; i <= frac; i++) begin
      r = {r[62:0], 1'b0};
      v = {v[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        v[0] = 1'b1;
      end
    end
    v = (v + 64'd1) >> 1;
    return neg ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic signed [63:0] pi_coef(input int frac);
    return fix_coef(64'd314159265358979324, 64'd100000000000000000, 1'b0, frac);
  endfunction

  // Starting value of the Horner accumulator (top coefficient)
  function automatic logic signed [63:0] init_coef(input mode_e mode, input int frac);
    logic signed [63:0] c;
    unique case (mode)
      MODE_TAYLOR7: c = fix_coef(64'd29, 64'd151200, 1'b1, frac);
      MODE_TAYLOR9: c = fix_coef(64'd44, 64'd16329600, 1'b0, frac);
      default:      c = fix_coef(64'd13291342, 64'd100000000000000000, 1'b0, frac);
    endcase
    return c;
  endfunction

  // Lower-order Taylor forms run on the last Horner steps only
  function automatic logic step_active(input int step, input mode_e mode);
    logic a;
    unique case (mode)
      MODE_TAYLOR7: a = (step >= 3);
      MODE_TAYLOR9: a = (step >= 2);
      default:      a = 1'b1;
    endcase
    return a;
  endfunction

  function automatic logic signed [63:0] step_coef(input int step, input mode_e mode,
                                                   input int frac);
    logic signed [63:0] c;
    c = '0;
    unique case (mode)
      MODE_TAYLOR7: begin
        if (step == 3) c = fix_coef(64'd1, 64'd120, 1'b0, frac);
        if (step == 4) c = fix_coef(64'd1, 64'd6, 1'b1, frac);
      end
      MODE_TAYLOR9: begin
        if (step == 2) c = fix_coef(64'd1, 64'd5040, 1'b1, frac);
        if (step == 3) c = fix_coef(64'd1, 64'd120, 1'b0, frac);
        if (step == 4) c = fix_coef(64'd1, 64'd6, 1'b1, frac);
      end
      default: begin
        if (step == 0) c = fix_coef(64'd23317787, 64'd1000000000000000, 1'b1, frac);
        if (step == 1) c = fix_coef(64'd25222919, 64'd10000000000000, 1'b0, frac);
        if (step == 2) c = fix_coef(64'd17350505, 64'd100000000000, 1'b1, frac);
        if (step == 3) c = fix_coef(64'd66208798, 64'd10000000000, 1'b0, frac);
        if (step == 4) c = fix_coef(64'd10132118, 64'd100000000, 1'b1, frac);
      end
    endcase
    return c;
  endfunction

endpackage

// File: design/spa_front.sv
// spa_front: two pipeline stages forming x, x^2, the outer factor and the
// Horner start value. Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_front import spa_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [ANGLE_W-1:0]   angle_i,
  input  mode_e                       mode_i,
  input  logic                        en_next_i,
  output logic                        en_o,
  output logic                        valid_o,
  output mode_e                       mode_o,
  output logic signed [DATA_WIDTH+5:0] x_o,
  output logic signed [DATA_WIDTH+5:0] x2_o,
  output logic signed [DATA_WIDTH+5:0] m_o,
  output logic signed [DATA_WIDTH+5:0] t_o
);

  localparam int FRAC = DATA_WIDTH - 2;
  localparam int W    = DATA_WIDTH + 6;
  localparam int W2   = 2 * W;
  localparam logic signed [W-1:0] PI_FIX = W'(pi_coef(FRAC));

  logic signed [W-1:0]  x_c;
  logic signed [W2-1:0] x2_prod, q_prod, xx2_prod;
  logic signed [W-1:0]  xm_c, xp_c;

  logic                 v1_q, v2_q;
  logic                 en1, en2;
  mode_e                mode1_q, mode2_q;
  logic signed [W-1:0]  x1_q, x21_q, q1_q;
  logic signed [W-1:0]  x2s_q, x22_q, m2_q, t2_q;
  logic signed [W-1:0]  m_d, t_d;

  // angle: Q29 -> FRAC fraction bits
  if (FRAC >= 29) begin : g_up
    assign x_c = W'(angle_i) <<< (FRAC - 29);
  end else begin : g_down
    logic signed [ANGLE_W-1:0] sh;
    assign sh  = angle_i >>> (29 - FRAC);
    assign x_c = W'(sh);
  end

  assign xm_c    = x_c - PI_FIX;
  assign xp_c    = x_c + PI_FIX;
  assign x2_prod = W2'(x_c) * W2'(x_c);
  assign q_prod  = W2'(xm_c) * W2'(xp_c);

  assign en2 = !v2_q || en_next_i;
  assign en1 = !v1_q || en2;
  assign en_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mode1_q <= mode_i;
      x1_q    <= x_c;
      x21_q   <= x2_prod[FRAC +: W];
      q1_q    <= q_prod[FRAC +: W];
    end
  end

  assign xx2_prod = W2'(x1_q) * W2'(x21_q);

  always_comb begin
    unique case (mode1_q)
      MODE_TAYLOR7: begin
        m_d = xx2_prod[FRAC +: W];
        t_d = W'(init_coef(MODE_TAYLOR7, FRAC));
      end
      MODE_TAYLOR9: begin
        m_d = xx2_prod[FRAC +: W];
        t_d = W'(init_coef(MODE_TAYLOR9, FRAC));
      end
      default: begin
        m_d = q1_q;
        t_d = W'(init_coef(MODE_CHEB, FRAC));
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      mode2_q <= mode1_q;
      x2s_q   <= x1_q;
      x22_q   <= x21_q;
      m2_q    <= m_d;
      t2_q    <= t_d;
    end
  end

  assign valid_o = v2_q;
  assign mode_o  = mode2_q;
  assign x_o     = x2s_q;
  assign x2_o    = x22_q;
  assign m_o     = m2_q;
  assign t_o     = t2_q;

endmodule

// File: design/spa_horner_step.sv
// spa_horner_step: one registered Horner step t = t*x^2 + c, bypassed for
// modes that do not use it. Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_horner_step import spa_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int STEP       = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  mode_e                       mode_i,
  input  logic signed [DATA_WIDTH+5:0] x_i,
  input  logic signed [DATA_WIDTH+5:0] x2_i,
  input  logic signed [DATA_WIDTH+5:0] m_i,
  input  logic signed [DATA_WIDTH+5:0] t_i,
  input  logic                        en_next_i,
  output logic                        en_o,
  output logic                        valid_o,
  output mode_e                       mode_o,
  output logic signed [DATA_WIDTH+5:0] x_o,
  output logic signed [DATA_WIDTH+5:0] x2_o,
  output logic signed [DATA_WIDTH+5:0] m_o,
  output logic signed [DATA_WIDTH+5:0] t_o
);

  localparam int FRAC = DATA_WIDTH - 2;
  localparam int W    = DATA_WIDTH + 6;
  localparam int W2   = 2 * W;
  localparam logic signed [W-1:0] C_T7 = W'(step_coef(STEP, MODE_TAYLOR7, FRAC));
  localparam logic signed [W-1:0] C_T9 = W'(step_coef(STEP, MODE_TAYLOR9, FRAC));
  localparam logic signed [W-1:0] C_CH = W'(step_coef(STEP, MODE_CHEB, FRAC));
  localparam logic A_T7 = step_active(STEP, MODE_TAYLOR7);
  localparam logic A_T9 = step_active(STEP, MODE_TAYLOR9);
  localparam logic A_CH = step_active(STEP, MODE_CHEB);

  logic signed [W2-1:0] prod;
  logic signed [W-1:0]  tp, coef, t_d;
  logic                 act, en, v_q;
  mode_e                mode_q;
  logic signed [W-1:0]  x_q, x2_q, m_q, t_q;

  assign prod = W2'(t_i) * W2'(x2_i);
  assign tp   = prod[FRAC +: W];

  always_comb begin
    unique case (mode_i)
      MODE_TAYLOR7: begin
        coef = C_T7;
        act  = A_T7;
      end
      MODE_TAYLOR9: begin
        coef = C_T9;
        act  = A_T9;
      end
      default: begin
        coef = C_CH;
        act  = A_CH;
      end
    endcase
    t_d = act ? tp + coef : t_i;
  end

  assign en   = !v_q || en_next_i;
  assign en_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_q <= mode_i;
      x_q    <= x_i;
      x2_q   <= x2_i;
      m_q    <= m_i;
      t_q    <= t_d;
    end
  end

  assign valid_o = v_q;
  assign mode_o  = mode_q;
  assign x_o     = x_q;
  assign x2_o    = x2_q;
  assign m_o     = m_q;
  assign t_o     = t_q;

endmodule

// File: design/spa_tail.sv
// spa_tail: final two products, rescale to Q30, saturation and the output
// register. Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_tail import spa_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  mode_e                        mode_i,
  input  logic signed [DATA_WIDTH+5:0] x_i,
  input  logic signed [DATA_WIDTH+5:0] m_i,
  input  logic signed [DATA_WIDTH+5:0] t_i,
  input  logic                         out_stall_i,
  output logic                         en_o,
  output logic                         out_valid_o,
  output logic signed [RESULT_W-1:0]   sine_value_o
);

  localparam int FRAC = DATA_WIDTH - 2;
  localparam int W    = DATA_WIDTH + 6;
  localparam int W2   = 2 * W;
  localparam int R    = W + 8;
  localparam logic signed [R-1:0] SAT_POS = R'(2 ** 30);
  localparam logic signed [R-1:0] SAT_NEG = -SAT_POS;

  logic signed [W2-1:0] pa_prod, pb_prod;
  logic                 va_q, vb_q, vo_q;
  logic                 ena, enb, eno;
  logic                 cheb_a_q;
  logic signed [W-1:0]  x_a_q, p_a_q, y_d, y_b_q;
  logic signed [R-1:0]  ys;
  logic signed [RESULT_W-1:0] out_d, out_q;

  assign eno  = !vo_q || !out_stall_i;
  assign enb  = !vb_q || eno;
  assign ena  = !va_q || enb;
  assign en_o = ena;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ena) va_q <= valid_i;
      if (enb) vb_q <= va_q;
      if (eno) vo_q <= vb_q;
    end
  end

  // stage A: outer factor times Horner value
  assign pa_prod = W2'(m_i) * W2'(t_i);

  always_ff @(posedge clk_i) begin
    if (ena) begin
      cheb_a_q <= (mode_i != MODE_TAYLOR7) && (mode_i != MODE_TAYLOR9);
      x_a_q    <= x_i;
      p_a_q    <= pa_prod[FRAC +: W];
    end
  end

  // stage B: Chebyshev multiplies by x, Taylor adds x
  assign pb_prod = W2'(p_a_q) * W2'(x_a_q);
  assign y_d     = cheb_a_q ? pb_prod[FRAC +: W] : x_a_q + p_a_q;

  always_ff @(posedge clk_i) begin
    if (enb) y_b_q <= y_d;
  end

  // stage C: FRAC -> Q30, clamp to +-1
  if (FRAC >= 30) begin : g_down
    logic signed [W-1:0] ysh;
    assign ysh = y_b_q >>> (FRAC - 30);
    assign ys  = R'(ysh);
  end else begin : g_up
    assign ys = R'(y_b_q) <<< (30 - FRAC);
  end

  always_comb begin
    priority if (ys > SAT_POS) begin
      out_d = RESULT_W'(SAT_POS);
    end else if (ys < SAT_NEG) begin
      out_d = RESULT_W'(SAT_NEG);
    end else begin
      out_d = RESULT_W'(ys);
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno) out_q <= out_d;
  end

  assign out_valid_o  = vo_q;
  assign sine_value_o = out_q;

endmodule

// File: design/sine_polynomial_approx.sv
// sine_polynomial_approx: top level of the odd-polynomial sine pipeline.
// Depends on spa_pkg, spa_front, spa_horner_step, spa_tail.
`timescale 1ns / 1ps

// Streaming fixed-point sine. Each transaction on the input channel carries
// one angle in radians (signed Q2.29); each output transaction carries its
// sine (signed Q1.30), saturated to +-1.0. poly_mode picks the polynomial:
// 0 = Taylor degree 7, 1 = Taylor degree 9 (both for |angle| <= pi/2),
// 2 = Chebyshev-fitted degree 13 over [-pi, pi]; writing 3 selects 2.
// Reset leaves mode 2. Throughput is one angle per clock while the output
// is not stalled. The pipeline has ten register stages: two front stages
// (x^2 and (x-pi)(x+pi), then x^3 and the Horner start), five Horner stages
// of one multiply-add each, two final product stages and the output
// register. The first front stage forms its two products side by side;
// every other stage has at most one multiplier of (DATA_WIDTH+6) bits, and
// the output register stage has none.
// Output stall freezes only the stages that hold data; empty stages keep
// filling, so in_stall_o rises only when all ten stages are occupied.
// Write poly_mode only while no transaction is in flight.
module sine_polynomial_approx import spa_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [MODE_W-1:0]          cfg_data_i,
  // angle in
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [ANGLE_W-1:0]  angle_i,
  // sine out
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [RESULT_W-1:0] sine_value_o
);

  localparam int W = DATA_WIDTH + 6;

  mode_e poly_mode_q, poly_mode_d;

  // pipeline links; index 0 is the front output, index k+1 the output of step k
  logic                valid_h [0:HORNER_STEPS];
  logic                en_h    [0:HORNER_STEPS];
  mode_e               mode_h  [0:HORNER_STEPS];
  logic signed [W-1:0] x_h     [0:HORNER_STEPS];
  logic signed [W-1:0] x2_h    [0:HORNER_STEPS];
  logic signed [W-1:0] m_h     [0:HORNER_STEPS];
  logic signed [W-1:0] t_h     [0:HORNER_STEPS];
  logic                front_en;

  // mode register; the unused code folds onto Chebyshev at write time
  assign cfg_ready_o = 1'b1;

  always_comb begin
    unique case (cfg_data_i)
      MODE_TAYLOR7: poly_mode_d = MODE_TAYLOR7;
      MODE_TAYLOR9: poly_mode_d = MODE_TAYLOR9;
      default:      poly_mode_d = MODE_CHEB;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_mode_q <= MODE_CHEB;
    end else if (cfg_valid_i && cfg_ready_o) begin
      poly_mode_q <= poly_mode_d;
    end
  end

  spa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .angle_i   (angle_i),
    .mode_i    (poly_mode_q),
    .en_next_i (en_h[0]),
    .en_o      (front_en),
    .valid_o   (valid_h[0]),
    .mode_o    (mode_h[0]),
    .x_o       (x_h[0]),
    .x2_o      (x2_h[0]),
    .m_o       (m_h[0]),
    .t_o       (t_h[0])
  );

  assign in_stall_o = !front_en;

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
    spa_horner_step #(.DATA_WIDTH(DATA_WIDTH), .STEP(k)) u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (valid_h[k]),
      .mode_i    (mode_h[k]),
      .x_i       (x_h[k]),
      .x2_i      (x2_h[k]),
      .m_i       (m_h[k]),
      .t_i       (t_h[k]),
      .en_next_i (en_h[k+1]),
      .en_o      (en_h[k]),
      .valid_o   (valid_h[k+1]),
      .mode_o    (mode_h[k+1]),
      .x_o       (x_h[k+1]),
      .x2_o      (x2_h[k+1]),
      .m_o       (m_h[k+1]),
      .t_o       (t_h[k+1])
    );
  end

  // x^2 of the last step is not needed further on
  spa_tail #(.DATA_WIDTH(DATA_WIDTH)) u_tail (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_h[HORNER_STEPS]),
    .mode_i       (mode_h[HORNER_STEPS]),
    .x_i          (x_h[HORNER_STEPS]),
    .m_i          (m_h[HORNER_STEPS]),
    .t_i          (t_h[HORNER_STEPS]),
    .out_stall_i  (out_stall_i),
    .en_o         (en_h[HORNER_STEPS]),
    .out_valid_o  (out_valid_o),
    .sine_value_o (sine_value_o)
  );

  // result never leaves the +-1.0 band
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sine_value_o <= 32'sd1073741824 &&
                     sine_value_o >= -32'sd1073741824))
    else $error("sine_value_o outside saturation range");

  // backpressure reaches the input only through a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output side is free");

  // mode changes only on a configuration transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> $stable(poly_mode_q))
    else $error("poly_mode changed without a write");

endmodule
